>>> hdl/isef_pkg.sv
// ----------------------------------------------------------------------------
// isef_pkg
// Shared types and constants of the induced subgraph edge fitness block.
// ----------------------------------------------------------------------------
package isef_pkg;

   localparam int ROW_W    = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int TOTAL_W  = 12;
   localparam int FIT_W    = 13;
   localparam int CSR_W    = 7;
   localparam int CSR_IX_W = 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [CSR_IX_W-1:0] CSR_NUM_NODES = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_TARGET_K  = 1'd1;

   localparam logic [CNT_W-1:0] NUM_NODES_RESET = 7'd64;
   localparam logic [CNT_W-1:0] TARGET_K_RESET  = 7'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             load_wr;
      logic             capture;
      logic             rd_en;
      logic             out_wr;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic no_nodes;
      logic out_free;
   } sts_type;

endpackage

>>> hdl/isef_if.sv
// ----------------------------------------------------------------------------
// isef_req_if / isef_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface isef_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [isef_pkg::IDX_W-1:0]   row_index;
   logic [isef_pkg::ROW_W-1:0]   row_bits;
   logic [isef_pkg::ROW_W-1:0]   selection;

   modport source (output valid, operation, row_index, row_bits, selection, input ready);
   modport sink   (input valid, operation, row_index, row_bits, selection, output ready);
endinterface

interface isef_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [isef_pkg::FIT_W-1:0] fitness;
   logic                             size_ok;

   modport source (output valid, fitness, size_ok, input ready);
   modport sink   (input valid, fitness, size_ok, output ready);
endinterface

>>> hdl/induced_subgraph_edge_fitness_top.sv
// ----------------------------------------------------------------------------
// induced_subgraph_edge_fitness_top
// Edge count of the subgraph induced by a node selection, with size check.
// ----------------------------------------------------------------------------
// Request words arrive on req_if. A load word (operation 0) writes row_bits
// into adjacency row row_index as it is taken; one load per cycle when idle.
// An evaluate word (operation 1) scans rows 0..N-1, N = min(num_nodes,
// MAX_NODES), one row read and popcounted per cycle through the single read
// port of the row store. Its response word carries the edge count (i <= j,
// self-loops counted) and size_ok; fitness is negated when the selected-node
// count differs from target_k.
// The evaluate passes from the scan state through a wait state to the done
// state, which writes the response register; when N is zero it goes straight
// from idle to the done state. The next request is taken once the controller
// is back in idle, so no new request is taken while an evaluate runs.
// The response sits in an output register: new requests are taken while it
// waits; a finished evaluate holds until rsp_if.ready frees that register.
// csr_ writes set num_nodes (index 0) and target_k (index 1).
// Reset clears control state and restores num_nodes 64 and target_k 0;
// the adjacency rows are undefined until loaded.
// ----------------------------------------------------------------------------
module induced_subgraph_edge_fitness_top #(
   parameter int MAX_NODES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   isef_req_if.sink                       req_if,
   isef_rsp_if.source                     rsp_if,
   input  logic                           csr_wr_en,
   input  logic [isef_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [isef_pkg::CSR_W-1:0]     csr_wdata
);

   isef_pkg::cmd_type cmd;
   isef_pkg::sts_type sts;

   isef_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (req_if.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   isef_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_row_index (req_if.row_index),
      .req_row_bits  (req_if.row_bits),
      .req_selection (req_if.selection),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_fitness   (rsp_if.fitness),
      .rsp_size_ok   (rsp_if.size_ok)
   );

endmodule

>>> hdl/isef_ctrl.sv
// ----------------------------------------------------------------------------
// isef_ctrl
// Sequencer: accepts words, steps the row scan, hands results to the output.
// ----------------------------------------------------------------------------
module isef_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_ready,
   input  isef_pkg::sts_type   sts,
   output isef_pkg::cmd_type   cmd
);

   isef_pkg::state_type           state_ff, state_in;
   logic [isef_pkg::IDX_W-1:0]    idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isef_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         isef_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == isef_pkg::OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  idx_in      = '0;
                  state_in    = sts.no_nodes ? isef_pkg::ST_DONE : isef_pkg::ST_SCAN;
               end
            end
         end
         isef_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (sts.last) begin
               state_in = isef_pkg::ST_WAIT;
            end
         end
         isef_pkg::ST_WAIT: begin
            state_in = isef_pkg::ST_DONE;
         end
         isef_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_wr = 1'b1;
               state_in   = isef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isef_pkg::ST_IDLE;
         end
      endcase
   end

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_wr |-> sts.out_free)
      else $error("result written over a pending word");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && !sts.no_nodes) |=> (state_ff == isef_pkg::ST_SCAN && idx_ff == '0))
      else $error("scan did not start at row zero");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isef_pkg::ST_SCAN && sts.last) |=> state_ff == isef_pkg::ST_WAIT)
      else $error("scan overran last row");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_wr || cmd.capture) |-> (req_valid && req_ready))
      else $error("row write or capture without accepted word");

endmodule

>>> hdl/isef_datapath.sv
// ----------------------------------------------------------------------------
// isef_datapath
// Adjacency row store, selection register, edge and node counters, output.
// ----------------------------------------------------------------------------
module isef_datapath #(
   parameter int MAX_NODES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  isef_pkg::cmd_type                    cmd,
   output isef_pkg::sts_type                    sts,
   input  logic [isef_pkg::IDX_W-1:0]           req_row_index,
   input  logic [isef_pkg::ROW_W-1:0]           req_row_bits,
   input  logic [isef_pkg::ROW_W-1:0]           req_selection,
   input  logic                                 csr_wr_en,
   input  logic [isef_pkg::CSR_IX_W-1:0]        csr_index,
   input  logic [isef_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [isef_pkg::FIT_W-1:0]    rsp_fitness,
   output logic                                 rsp_size_ok
);

   localparam int AW = $clog2(MAX_NODES);
   localparam logic [isef_pkg::CNT_W-1:0] MAX_N = isef_pkg::CNT_W'(MAX_NODES);

   logic [isef_pkg::ROW_W-1:0]   row_mem_ff [MAX_NODES];
   logic [isef_pkg::ROW_W-1:0]   rd_q_ff;
   logic                         acc_pend_ff;
   logic [isef_pkg::IDX_W-1:0]   acc_idx_ff;
   logic [isef_pkg::ROW_W-1:0]   sel_ff, sel_in;
   logic [isef_pkg::TOTAL_W-1:0] total_ff;
   logic [isef_pkg::CNT_W-1:0]   chosen_ff;
   logic [isef_pkg::CNT_W-1:0]   num_nodes_ff, target_k_ff;
   logic [isef_pkg::CNT_W-1:0]   n_eff;
   logic [isef_pkg::ROW_W-1:0]   hit;
   logic [isef_pkg::CNT_W-1:0]   hit_cnt;
   logic                         out_valid_ff;
   logic signed [isef_pkg::FIT_W-1:0] fit_ff;
   logic                         size_ok_ff;
   logic                         match;

   function automatic logic [isef_pkg::CNT_W-1:0] popcount(input logic [isef_pkg::ROW_W-1:0] v);
      logic [isef_pkg::CNT_W-1:0] c;
      c = '0;
      for (int j = 0; j < isef_pkg::ROW_W; j++) begin
         c = c + isef_pkg::CNT_W'(v[j]);
      end
      return c;
   endfunction

   assign n_eff = (num_nodes_ff > MAX_N) ? MAX_N : num_nodes_ff;

   always_comb begin
      for (int j = 0; j < isef_pkg::ROW_W; j++) begin
         sel_in[j] = req_selection[j] & (isef_pkg::CNT_W'(j) < n_eff);
         hit[j]    = rd_q_ff[j] & sel_ff[j] & (isef_pkg::IDX_W'(j) >= acc_idx_ff);
      end
   end

   assign hit_cnt = popcount(hit);

   assign sts.last     = ({1'b0, cmd.idx} == (n_eff - 1'b1));
   assign sts.no_nodes = (n_eff == '0);
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= isef_pkg::NUM_NODES_RESET;
         target_k_ff  <= isef_pkg::TARGET_K_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            isef_pkg::CSR_NUM_NODES: num_nodes_ff <= csr_wdata;
            isef_pkg::CSR_TARGET_K:  target_k_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && ({1'b0, req_row_index} < MAX_N)) begin
         row_mem_ff[req_row_index[AW-1:0]] <= req_row_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_q_ff <= row_mem_ff[cmd.idx[AW-1:0]];
      end
      acc_idx_ff <= cmd.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_pend_ff <= 1'b0;
      end else begin
         acc_pend_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sel_ff    <= sel_in;
         total_ff  <= '0;
         chosen_ff <= '0;
      end else if (acc_pend_ff && sel_ff[acc_idx_ff]) begin
         total_ff  <= total_ff + isef_pkg::TOTAL_W'(hit_cnt);
         chosen_ff <= chosen_ff + 1'b1;
      end
   end

   assign match = (chosen_ff == target_k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_wr) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_wr) begin
         fit_ff     <= match ? $signed({1'b0, total_ff}) : -$signed({1'b0, total_ff});
         size_ok_ff <= match;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_fitness = fit_ff;
   assign rsp_size_ok = size_ok_ff;

endmodule
